/* src/mcd_pkg.sv */
// ----------------------------------------------------------------------------
// mcd_pkg: shared types and constants for the maze carver
// Grid and stack sizes, stack entry layout, direction codes, command codes
// and the controller state encoding.
// ----------------------------------------------------------------------------
package mcd_pkg;

  // Grid and stack geometry
  localparam int MaxWidth   = 64;
  localparam int MaxHeight  = 64;
  localparam int StackDepth = 1024;

  localparam int CoordW  = 6;                       // column / row field width
  localparam int CellAw  = 2 * CoordW;              // grid address {row, col}
  localparam int GridCells = MaxWidth * MaxHeight;
  localparam int StackAw = $clog2(StackDepth);      // stack memory address
  localparam int CountW  = StackAw + 1;             // fill count, holds the depth
  localparam int SizeW   = 7;                       // size register width

  localparam logic [SizeW-1:0]  SizeReset = SizeW'(MaxWidth);
  localparam logic [CountW-1:0] StackFull = CountW'(StackDepth);

  // Command codes
  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_STEP  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_BAD   = 2'd3
  } action_t;

  // Configuration register indexes
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // Directions, in their unshuffled order
  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_E = 2'd1;
  localparam logic [1:0] DIR_S = 2'd2;
  localparam logic [1:0] DIR_W = 2'd3;

  // One stack entry: cell, shuffled direction order, next try index
  typedef struct packed {
    logic [CoordW-1:0]  cx;
    logic [CoordW-1:0]  cy;
    logic [3:0][1:0]    order;
    logic [2:0]         nxt;
  } entry_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SEED,
    ST_PROBE,
    ST_CARVE,
    ST_POP,
    ST_READ
  } state_t;

endpackage

/* src/maze_carver_dfs.sv */
// ----------------------------------------------------------------------------
// maze_carver_dfs: randomised depth-first backtracking maze carver
// Grid of open/wall bits and the backtracking stack both sit in synchronous
// simple dual-port memories; a small sequencer reads, modifies and writes.
// ----------------------------------------------------------------------------
// Issue a command with start while busy is low; exactly one result beat
// follows on out_valid, held for a single cycle, and the receiver cannot stall
// it. After reset the grid memory is cleared one cell per cycle with busy
// high. A start inside the border repeats that clearing pass and then seeds
// the start cell; a rejected start answers without clearing. A carve step
// blocked by border or full stack answers without a memory access; else the
// target cell is fetched from the grid memory and, if still wall, carved and
// pushed before a second grid write opens the wall between. A pop may fetch
// the entry below from the stack memory; a read waits on the grid memory
// read register. The next command may be issued in the cycle of the result
// beat. top_x, top_y and finished reflect the stack after the command.
// ----------------------------------------------------------------------------
module maze_carver_dfs
  import mcd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // command channel
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_action,
  input  logic [CoordW-1:0] in_x,
  input  logic [CoordW-1:0] in_y,
  input  logic [7:0]        in_shuffle_picks,
  // result channel
  output logic              out_valid,
  output logic              out_cell_open,
  output logic [CoordW-1:0] out_top_x,
  output logic [CoordW-1:0] out_top_y,
  output logic              out_carved,
  output logic              out_finished,
  output logic              out_rejected,
  // configuration
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [SizeW-1:0]  cfg_wdata
);

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------

  // Shuffle N,E,S,W: position i swapped with the pick for i, in order
  function automatic logic [3:0][1:0] shuffle(input logic [7:0] picks);
    logic [3:0][1:0] ord;
    logic [1:0]      tmp;
    logic [1:0]      r;
    ord[0] = DIR_N;
    ord[1] = DIR_E;
    ord[2] = DIR_S;
    ord[3] = DIR_W;
    for (int i = 0; i < 4; i++) begin
      r      = picks[2*i +: 2];
      tmp    = ord[r];
      ord[r] = ord[i];
      ord[i] = tmp;
    end
    return ord;
  endfunction

  // 1 <= c <= size-2, with c allowed to have wrapped below zero
  function automatic logic in_border(input logic [7:0] c, input logic [SizeW-1:0] size);
    return (c != 8'd0) && ((9'(c) + 9'd2) <= 9'(size));
  endfunction

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t              state_r,    state_nxt;
  logic [SizeW-1:0]    width_r,    height_r;
  logic [CountW-1:0]   count_r,    count_nxt;
  entry_t              top_r,      top_nxt;
  logic [CellAw-1:0]   clr_addr_r, clr_addr_nxt;
  logic                clr_seed_r, clr_seed_nxt;
  logic [CoordW-1:0]   tgt_x_r,    tgt_x_nxt;
  logic [CoordW-1:0]   tgt_y_r,    tgt_y_nxt;
  logic [CellAw-1:0]   mid_addr_r, mid_addr_nxt;
  logic [7:0]          picks_r,    picks_nxt;
  logic                valid_r,    valid_nxt;
  logic                open_r,     open_nxt;
  logic                carved_r,   carved_nxt;
  logic                rejected_r, rejected_nxt;

  // Memory ports
  logic                grid_we;
  logic [CellAw-1:0]   grid_waddr;
  logic                grid_wdata;
  logic [CellAw-1:0]   grid_raddr;
  logic                grid_rdata_r;
  logic                stk_we;
  logic [StackAw-1:0]  stk_waddr;
  entry_t              stk_wdata;
  logic [StackAw-1:0]  stk_raddr;
  entry_t              stk_rdata_r;

  // Grid of open bits (1 = carved) and the stack below the top entry
  logic                grid_mem [GridCells];
  entry_t              stk_mem  [StackDepth];

  // --------------------------------------------------------------------------
  // Size in use, limited to the stored grid
  // --------------------------------------------------------------------------
  logic [SizeW-1:0] eff_w, eff_h;
  assign eff_w = (width_r  > SizeW'(MaxWidth))  ? SizeW'(MaxWidth)  : width_r;
  assign eff_h = (height_r > SizeW'(MaxHeight)) ? SizeW'(MaxHeight) : height_r;

  // --------------------------------------------------------------------------
  // Step decode from the top entry
  // --------------------------------------------------------------------------
  logic [1:0] dir;
  logic [7:0] step_tx, step_ty, step_mx, step_my;
  logic       step_ok;

  always_comb begin
    dir     = top_r.order[top_r.nxt[1:0]];
    step_tx = {2'b00, top_r.cx};
    step_ty = {2'b00, top_r.cy};
    step_mx = {2'b00, top_r.cx};
    step_my = {2'b00, top_r.cy};
    case (dir)
      DIR_N: begin
        step_ty = step_ty - 8'd2;
        step_my = step_my - 8'd1;
      end
      DIR_E: begin
        step_tx = step_tx + 8'd2;
        step_mx = step_mx + 8'd1;
      end
      DIR_S: begin
        step_ty = step_ty + 8'd2;
        step_my = step_my + 8'd1;
      end
      default: begin
        step_tx = step_tx - 8'd2;
        step_mx = step_mx - 8'd1;
      end
    endcase
    step_ok = in_border(step_tx, eff_w) && in_border(step_ty, eff_h) &&
              (count_r < StackFull);
  end

  logic start_ok;
  assign start_ok = in_border({2'b00, in_x}, eff_w) && in_border({2'b00, in_y}, eff_h);

  // --------------------------------------------------------------------------
  // Sequencer: state register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      count_r    <= '0;
      clr_addr_r <= '0;
      clr_seed_r <= 1'b0;
      valid_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      clr_addr_r <= clr_addr_nxt;
      clr_seed_r <= clr_seed_nxt;
      valid_r    <= valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    tgt_x_r    <= tgt_x_nxt;
    tgt_y_r    <= tgt_y_nxt;
    mid_addr_r <= mid_addr_nxt;
    picks_r    <= picks_nxt;
    open_r     <= open_nxt;
    carved_r   <= carved_nxt;
    rejected_r <= rejected_nxt;
  end

  // size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SizeReset;
      height_r <= SizeReset;
    end else if (cfg_we) begin
      if (cfg_index == CFG_WIDTH) begin
        width_r <= cfg_wdata;
      end
      if (cfg_index == CFG_HEIGHT) begin
        height_r <= cfg_wdata;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state, memory accesses and result
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    top_nxt      = top_r;
    clr_addr_nxt = clr_addr_r;
    clr_seed_nxt = clr_seed_r;
    tgt_x_nxt    = tgt_x_r;
    tgt_y_nxt    = tgt_y_r;
    mid_addr_nxt = mid_addr_r;
    picks_nxt    = picks_r;
    valid_nxt    = 1'b0;
    open_nxt     = 1'b0;
    carved_nxt   = 1'b0;
    rejected_nxt = 1'b0;

    grid_we    = 1'b0;
    grid_waddr = clr_addr_r;
    grid_wdata = 1'b0;
    grid_raddr = {step_ty[CoordW-1:0], step_tx[CoordW-1:0]};
    stk_we     = 1'b0;
    stk_waddr  = StackAw'(count_r - CountW'(1));
    stk_wdata  = top_r;
    stk_raddr  = StackAw'(count_r - CountW'(2));

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          picks_nxt = in_shuffle_picks;
          case (in_action)
            ACT_START: begin
              if (start_ok) begin
                tgt_x_nxt    = in_x;
                tgt_y_nxt    = in_y;
                clr_addr_nxt = '0;
                clr_seed_nxt = 1'b1;
                state_nxt    = ST_CLEAR;
              end else begin
                valid_nxt    = 1'b1;
                rejected_nxt = 1'b1;
              end
            end
            ACT_STEP: begin
              if (count_r == '0) begin
                valid_nxt    = 1'b1;
                rejected_nxt = 1'b1;
              end else if (top_r.nxt[2]) begin
                // all four tried: pop, fetching the entry below if any
                if (count_r == CountW'(1)) begin
                  count_nxt = '0;
                  valid_nxt = 1'b1;
                end else begin
                  state_nxt = ST_POP;
                end
              end else begin
                top_nxt.nxt  = top_r.nxt + 3'd1;
                tgt_x_nxt    = step_tx[CoordW-1:0];
                tgt_y_nxt    = step_ty[CoordW-1:0];
                mid_addr_nxt = {step_my[CoordW-1:0], step_mx[CoordW-1:0]};
                if (step_ok) begin
                  state_nxt = ST_PROBE;     // fetch target cell
                end else begin
                  valid_nxt = 1'b1;
                end
              end
            end
            ACT_READ: begin
              grid_raddr = {in_y, in_x};
              state_nxt  = ST_READ;
            end
            default: begin
              valid_nxt    = 1'b1;
              rejected_nxt = 1'b1;
            end
          endcase
        end
      end

      // wipe the grid back to walls, one cell a cycle
      ST_CLEAR: begin
        grid_we      = 1'b1;
        grid_waddr   = clr_addr_r;
        grid_wdata   = 1'b0;
        clr_addr_nxt = clr_addr_r + CellAw'(1);
        if (clr_addr_r == CellAw'(GridCells - 1)) begin
          state_nxt = clr_seed_r ? ST_SEED : ST_IDLE;
        end
      end

      // open the start cell and make it the only entry
      ST_SEED: begin
        grid_we      = 1'b1;
        grid_waddr   = {tgt_y_r, tgt_x_r};
        grid_wdata   = 1'b1;
        top_nxt.cx   = tgt_x_r;
        top_nxt.cy   = tgt_y_r;
        top_nxt.order = shuffle(picks_r);
        top_nxt.nxt  = 3'd0;
        count_nxt    = CountW'(1);
        clr_seed_nxt = 1'b0;
        valid_nxt    = 1'b1;
        state_nxt    = ST_IDLE;
      end

      // target fetched: carve and push if still wall
      ST_PROBE: begin
        if (!grid_rdata_r) begin
          grid_we       = 1'b1;
          grid_waddr    = {tgt_y_r, tgt_x_r};
          grid_wdata    = 1'b1;
          stk_we        = 1'b1;
          stk_wdata     = top_r;
          top_nxt.cx    = tgt_x_r;
          top_nxt.cy    = tgt_y_r;
          top_nxt.order = shuffle(picks_r);
          top_nxt.nxt   = 3'd0;
          count_nxt     = count_r + CountW'(1);
          state_nxt     = ST_CARVE;
        end else begin
          valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      // open the wall between
      ST_CARVE: begin
        grid_we    = 1'b1;
        grid_waddr = mid_addr_r;
        grid_wdata = 1'b1;
        carved_nxt = 1'b1;
        valid_nxt  = 1'b1;
        state_nxt  = ST_IDLE;
      end

      // entry below arrives from the stack memory
      ST_POP: begin
        top_nxt   = stk_rdata_r;
        count_nxt = count_r - CountW'(1);
        valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end

      ST_READ: begin
        open_nxt  = grid_rdata_r;
        valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (grid_we) begin
      grid_mem[grid_waddr] <= grid_wdata;
    end
    grid_rdata_r <= grid_mem[grid_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rdata_r <= stk_mem[stk_raddr];
  end

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = valid_r;
  assign out_cell_open = open_r;
  assign out_carved    = carved_r;
  assign out_rejected  = rejected_r;
  assign out_finished  = (count_r == '0);
  assign out_top_x     = (count_r == '0) ? '0 : top_r.cx;
  assign out_top_y     = (count_r == '0) ? '0 : top_r.cy;

endmodule

/* sim/maze_carver_dfs_tb.sv */
// ----------------------------------------------------------------------------
// maze_carver_dfs_tb: self-checking bench for the depth-first maze carver
// A behavioural copy of the carver (wall grid, backtracking stack, size
// registers) predicts every result beat. Directed commands cover the corners,
// then random carving sessions, with bad and out-of-border commands mixed in,
// run over several grid sizes and idling rates. Each beat is compared field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------
module maze_carver_dfs_tb;
  import mcd_pkg::*;

  localparam int StallLimit = 20000;   // covers a clearing start plus a long gap
  localparam int MaxReports = 10;

  // one predicted result beat, fields in port order
  typedef struct packed {
    logic              cell_open;
    logic [CoordW-1:0] top_x;
    logic [CoordW-1:0] top_y;
    logic              carved;
    logic              finished;
    logic              rejected;
  } beat_t;

  // backtracking frame: cell, shuffled directions, tries made so far
  typedef struct packed {
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic [3:0][1:0]   dirs;
    logic [2:0]        tries;
  } frame_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        in_action = ACT_READ;
  logic [CoordW-1:0] in_x = '0;
  logic [CoordW-1:0] in_y = '0;
  logic [7:0]        in_shuffle_picks = '0;
  logic              out_valid;
  logic              out_cell_open;
  logic [CoordW-1:0] out_top_x;
  logic [CoordW-1:0] out_top_y;
  logic              out_carved;
  logic              out_finished;
  logic              out_rejected;
  logic              cfg_we = 1'b0;
  logic              cfg_index = CFG_WIDTH;
  logic [SizeW-1:0]  cfg_wdata = '0;

  // predicted carver state
  bit               wall_map [MaxHeight][MaxWidth];
  frame_t           path_mem [StackDepth];
  int               path_depth;
  logic [SizeW-1:0] cols_reg;
  logic [SizeW-1:0] rows_reg;

  beat_t pending_q[$];
  int    idle_pct;
  int    err_cnt;
  int    quiet_cycles;
  int    n_cmds, n_starts, n_cuts, n_open_reads, n_rejects;

  maze_carver_dfs dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_x             (in_x),
    .in_y             (in_y),
    .in_shuffle_picks (in_shuffle_picks),
    .out_valid        (out_valid),
    .out_cell_open    (out_cell_open),
    .out_top_x        (out_top_x),
    .out_top_y        (out_top_y),
    .out_carved       (out_carved),
    .out_finished     (out_finished),
    .out_rejected     (out_rejected),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int cols_used();
    return (cols_reg > MaxWidth) ? MaxWidth : int'(cols_reg);
  endfunction

  function automatic int rows_used();
    return (rows_reg > MaxHeight) ? MaxHeight : int'(rows_reg);
  endfunction

  function automatic bit in_border(int cx, int cy);
    return (cx >= 1) && (cx <= cols_used() - 2) && (cy >= 1) && (cy <= rows_used() - 2);
  endfunction

  function automatic void fill_walls();
    foreach (wall_map[r, c]) wall_map[r][c] = 1'b1;
  endfunction

  // new frame with directions shuffled by the four 2-bit swap partners
  function automatic void push_frame(int cx, int cy, logic [7:0] picks);
    frame_t     f;
    logic [1:0] tmp;
    logic [1:0] r;
    f.cx = CoordW'(cx);
    f.cy = CoordW'(cy);
    for (int i = 0; i < 4; i++) f.dirs[i] = 2'(i);
    for (int i = 0; i < 4; i++) begin
      r = picks[2*i +: 2];
      tmp = f.dirs[r];
      f.dirs[r] = f.dirs[i];
      f.dirs[i] = tmp;
    end
    f.tries = '0;
    path_mem[path_depth] = f;
    path_depth++;
  endfunction

  function automatic beat_t carve_predict(action_t act, int x, int y, logic [7:0] picks);
    beat_t  b;
    frame_t f;
    int     dx, dy, tx, ty;
    b = '0;
    case (act)
      ACT_START: begin
        if (!in_border(x, y)) begin
          b.rejected = 1'b1;
        end else begin
          fill_walls();
          path_depth = 0;
          wall_map[y][x] = 1'b0;
          push_frame(x, y, picks);
          n_starts++;
        end
      end
      ACT_STEP: begin
        if (path_depth == 0) begin
          b.rejected = 1'b1;
        end else begin
          f = path_mem[path_depth-1];
          if (f.tries >= 4) begin
            // every direction tried: backtrack
            path_depth--;
          end else begin
            case (f.dirs[f.tries[1:0]])
              DIR_N:   begin dx = 0;  dy = -1; end
              DIR_E:   begin dx = 1;  dy = 0;  end
              DIR_S:   begin dx = 0;  dy = 1;  end
              default: begin dx = -1; dy = 0;  end
            endcase
            tx = int'(f.cx) + 2 * dx;
            ty = int'(f.cy) + 2 * dy;
            path_mem[path_depth-1].tries = f.tries + 3'd1;
            if (in_border(tx, ty) && path_depth < StackDepth) begin
              if (wall_map[ty][tx]) begin
                wall_map[int'(f.cy) + dy][int'(f.cx) + dx] = 1'b0;
                wall_map[ty][tx] = 1'b0;
                push_frame(tx, ty, picks);
                b.carved = 1'b1;
                n_cuts++;
              end
            end
          end
        end
      end
      ACT_READ: begin
        b.cell_open = ~wall_map[y][x];
        if (b.cell_open) n_open_reads++;
      end
      default: b.rejected = 1'b1;
    endcase
    if (path_depth > 0) begin
      b.top_x = path_mem[path_depth-1].cx;
      b.top_y = path_mem[path_depth-1].cy;
    end
    b.finished = (path_depth == 0);
    if (b.rejected) n_rejects++;
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Command driver
  // ---------------------------------------------------------------------------
  // start stays high after an accepted beat, so the caller either sends the
  // next command in the same step or lowers start with lower_start
  task automatic send_cmd(input action_t act, input int x, input int y,
                          input logic [7:0] picks);
    int    gap;
    beat_t exp_beat;
    gap = 0;
    while (idle_pct != 0 && gap < 40 && $urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start            <= 1'b1;
    in_action        <= act;
    in_x             <= CoordW'(x);
    in_y             <= CoordW'(y);
    in_shuffle_picks <= picks;
    do @(posedge clk); while (busy);
    exp_beat  = carve_predict(act, x, y, picks);
    pending_q = {pending_q, exp_beat};
    n_cmds++;
  endtask

  task automatic lower_start();
    start <= 1'b0;
  endtask

  // size register write, only once the carver has gone quiet
  task automatic write_size(input logic idx, input logic [SizeW-1:0] val);
    lower_start();
    do @(posedge clk); while (busy || pending_q.size() != 0);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WIDTH) cols_reg = val;
    else rows_reg = val;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  function automatic void flag_error(string msg);
    err_cnt++;
    if (err_cnt <= MaxReports) $display("mismatch: %s", msg);
  endfunction

  always @(posedge clk) begin : result_check
    beat_t got, want;
    if (rst_n && out_valid) begin
      got = {out_cell_open, out_top_x, out_top_y, out_carved, out_finished, out_rejected};
      if (pending_q.size() == 0) begin
        flag_error($sformatf("unexpected beat %p", got));
      end else begin
        want = pending_q.pop_front();
        if (got !== want)
          flag_error($sformatf({"beat exp open=%0b top=(%0d,%0d) carved=%0b fin=%0b",
                                " rej=%0b, act open=%0b top=(%0d,%0d) carved=%0b",
                                " fin=%0b rej=%0b"},
                               want.cell_open, want.top_x, want.top_y, want.carved,
                               want.finished, want.rejected, got.cell_open, got.top_x,
                               got.top_y, got.carved, got.finished, got.rejected));
      end
    end
  end

  // watchdog: cycles with neither a command nor a result accepted
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // empty stack, unknown action, corner reads and starts on or past the border
  task automatic test_empty_and_noise();
    send_cmd(ACT_STEP, 0, 0, 8'h00);
    send_cmd(ACT_BAD, 63, 63, 8'hFF);
    send_cmd(ACT_READ, 0, 0, 8'h00);
    send_cmd(ACT_READ, 63, 63, 8'hFF);
    send_cmd(ACT_START, 0, 5, 8'h1B);
    send_cmd(ACT_START, 63, 63, 8'hE4);
    send_cmd(ACT_START, 5, 0, 8'h00);
  endtask

  // smallest grid: one cell, four blocked tries, a pop, then finished
  task automatic test_tiny_grid();
    write_size(CFG_WIDTH, 7'd3);
    write_size(CFG_HEIGHT, 7'd3);
    send_cmd(ACT_START, 1, 1, 8'hFF);
    repeat (5) send_cmd(ACT_STEP, 0, 0, 8'h00);
    send_cmd(ACT_STEP, 1, 1, 8'hAA);
    send_cmd(ACT_READ, 1, 1, 8'h00);
    send_cmd(ACT_READ, 2, 1, 8'h00);
    send_cmd(ACT_START, 2, 1, 8'h55);
  endtask

  // sizes below three leave no cell inside the border
  task automatic test_undersized_grid();
    write_size(CFG_WIDTH, 7'd0);
    write_size(CFG_HEIGHT, 7'd127);
    send_cmd(ACT_START, 1, 1, 8'h00);
    write_size(CFG_WIDTH, 7'd2);
    write_size(CFG_HEIGHT, 7'd2);
    send_cmd(ACT_START, 1, 1, 8'hFF);
    send_cmd(ACT_STEP, 1, 1, 8'h00);
  endtask

  // random carving sessions over several sizes and idling rates
  task automatic test_random_mazes();
    int sz_w [8] = '{9, 13, 3, 64, 127, 5, 21, 64};
    int sz_h [8] = '{7, 11, 64, 3, 127, 5, 17, 64};
    int idle_of [8] = '{0, 72, 9, 0, 72, 9, 0, 72};
    int sent, roll, cw, rh;
    for (int p = 0; p < 8; p++) begin
      write_size(CFG_WIDTH, SizeW'(sz_w[p]));
      write_size(CFG_HEIGHT, SizeW'(sz_h[p]));
      idle_pct = idle_of[p];
      cw = cols_used();
      rh = rows_used();
      sent = 0;
      while (sent < 180) begin
        // a new maze from a random cell inside the border
        send_cmd(ACT_START, $urandom_range(cw - 2, 1), $urandom_range(rh - 2, 1),
                 8'($urandom));
        sent++;
        while (sent < 180) begin
          roll = $urandom_range(99);
          if (roll < 80)
            send_cmd(ACT_STEP, $urandom_range(63), $urandom_range(63), 8'($urandom));
          else if (roll < 88)
            send_cmd(ACT_READ, $urandom_range(cw - 1), $urandom_range(rh - 1), 8'($urandom));
          else if (roll < 94)
            send_cmd(ACT_READ, $urandom_range(63), $urandom_range(63), 8'($urandom));
          else if (roll < 97)
            send_cmd(ACT_BAD, $urandom_range(63), $urandom_range(63), 8'($urandom));
          else
            send_cmd(ACT_START, $urandom_range(63), $urandom_range(63), 8'($urandom));
          sent++;
          // a finished maze usually ends the session, sometimes takes more steps
          if (path_depth == 0 && $urandom_range(2) != 0) break;
        end
      end
    end
    idle_pct = 0;
    lower_start();
  endtask

  task automatic finish_run();
    do @(posedge clk); while (pending_q.size() != 0);
    repeat (10) @(posedge clk);
    $display("covered %0d commands: %0d maze starts, %0d cells carved, %0d open reads",
             n_cmds, n_starts, n_cuts, n_open_reads);
    $display("%0d commands rejected, %0d mismatches", n_rejects, err_cnt);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  endtask

  initial begin
    cols_reg   = SizeReset;
    rows_reg   = SizeReset;
    path_depth = 0;
    idle_pct   = 0;
    err_cnt    = 0;
    fill_walls();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_and_noise();
    test_tiny_grid();
    test_undersized_grid();
    test_random_mazes();
    finish_run();
  end

endmodule
